// ----- rtl/fge_pkg.sv -----
package fge_pkg;

  // Word storage and field geometry.
  localparam int MAX_LEN  = 64;
  localparam int MAX_GENS = 26;
  localparam int ADDR_W   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int LEN_W    = $clog2(MAX_LEN + 1);
  localparam int FUNC_W   = 3;
  localparam int GEN_W    = 6;
  localparam int IDX_W    = 6;
  localparam int WLEN_W   = 7;
  localparam int NG_W     = 5;
  localparam int RANK_W   = 8;
  localparam int CMP_W    = (LEN_W > IDX_W) ? LEN_W : IDX_W;

  localparam logic [NG_W-1:0] NG_RESET = NG_W'(2);

  typedef logic signed [GEN_W-1:0] letter_t;
  typedef logic [ADDR_W-1:0]       addr_t;
  typedef logic [LEN_W-1:0]        len_t;
  typedef logic [RANK_W-1:0]       rank_t;

  localparam logic signed [GEN_W:0] GEN_HI = (GEN_W+1)'(MAX_GENS);
  localparam logic signed [GEN_W:0] GEN_LO = (GEN_W+1)'(-MAX_GENS);

  localparam letter_t LTR_ZERO  = letter_t'(0);
  localparam letter_t LTR_ONE   = letter_t'(1);
  localparam letter_t LTR_M_ONE = letter_t'(-1);

  typedef enum logic [FUNC_W-1:0] {
    FN_MUL_R = 3'd0,
    FN_MUL_L = 3'd1,
    FN_INV   = 3'd2,
    FN_NEXT  = 3'd3,
    FN_READ  = 3'd4,
    FN_SET   = 3'd5
  } func_t;

  // Physical slot of logical position i in the circular store.
  function automatic addr_t slot_addr(addr_t sp, len_t i);
    logic [LEN_W:0] s;
    s = (LEN_W+1)'(sp) + (LEN_W+1)'(i);
    if (s >= (LEN_W+1)'(MAX_LEN)) begin
      s = s - (LEN_W+1)'(MAX_LEN);
    end
    return ADDR_W'(s);
  endfunction

  function automatic letter_t neg_letter(letter_t l);
    return letter_t'(~l + 1'b1);
  endfunction

  // Shortlex rank: +k -> 2(k-1), -k -> 2(k-1)+1. With flip set, the rank of -l.
  function automatic rank_t rank_of(letter_t l, logic flip);
    logic [GEN_W:0] mag;
    mag = l[GEN_W-1] ? ({1'b0, ~l} + 1'b1) : {1'b0, l};
    return rank_t'({mag - 1'b1, l[GEN_W-1] ^ flip});
  endfunction

  function automatic letter_t letter_of(rank_t c);
    logic [GEN_W-1:0] g;
    g = GEN_W'(c[RANK_W-1:1]) + 1'b1;
    return c[0] ? letter_t'(GEN_W'(~g + 1'b1)) : letter_t'(g);
  endfunction

  function automatic logic gen_ok(letter_t g);
    logic signed [GEN_W:0] gx;
    gx = (GEN_W+1)'(g);
    return (gx >= GEN_LO) && (gx <= GEN_HI);
  endfunction

endpackage

// ----- rtl/fge_if.sv -----
interface fge_in_if import fge_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  letter_t           gen;
  logic [IDX_W-1:0]  index;

  modport source (output valid, func, gen, index, input ready);
  modport sink   (input valid, func, gen, index, output ready);
endinterface

interface fge_out_if import fge_pkg::*; ();
  logic              valid;
  logic              ready;
  letter_t           letter;
  logic [WLEN_W-1:0] word_length;
  logic              cancelled;
  logic              overflow;

  modport source (output valid, letter, word_length, cancelled, overflow, input ready);
  modport sink   (input valid, letter, word_length, cancelled, overflow, output ready);
endinterface

interface fge_cfg_if import fge_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [NG_W-1:0] num_gens;

  modport source (output valid, num_gens, input ready);
  modport sink   (input valid, num_gens, output ready);
endinterface

// ----- rtl/fge_ram.sv -----
module fge_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/free_group_word_engine.sv -----
// Channel | Dir | Fields                                        | Handshake
// in_ch   | in  | func[2:0], gen[5:0] signed, index[5:0]        | valid/ready
// out_ch  | out | letter[5:0] signed, word_length[6:0],         | valid/ready
//         |     | cancelled, overflow                           |
// cfg_ch  | in  | num_gens[4:0]                                 | valid/ready
//
// Set, the unused codes and inverting the empty word finish in the accept
// state; multiplies and reads finish in their evaluate state. Invert reads and
// writes each letter pair, a middle letter counting as a pair; next-word reads
// each position scanned from the right and writes each letter refilled, and
// finishes at the scan, with no fill, when it overflows. The letter memory has
// a single read port, and every letter visit is one read.
// Reset (rst_n, synchronous, active low) empties the word and sets num_gens to
// 2; the letter memory itself is not cleared. A stalled result waits in the
// output register and the next word is taken meanwhile; only the finish of
// that following word waits for the register to drain.
module free_group_word_engine import fge_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  fge_in_if.sink      in_ch,
  fge_out_if.source   out_ch,
  fge_cfg_if.sink     cfg_ch
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_EVAL,
    S_RD_DATA,
    S_INV_RA,
    S_INV_RB,
    S_INV_WA,
    S_INV_WB,
    S_NX_RP,
    S_NX_RQ,
    S_NX_EVAL,
    S_NX_FILL,
    S_DONE
  } state_t;

  state_t            state_r, state_nxt;
  func_t             func_r, func_nxt;
  letter_t           gen_r, gen_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  len_t              len_r, len_nxt;
  addr_t             sp_r, sp_nxt;
  logic [NG_W-1:0]   ng_r, ng_nxt;
  len_t              pos_r, pos_nxt;
  letter_t           tmp_r, tmp_nxt;
  letter_t           letter_r, letter_nxt;
  logic              canc_r, canc_nxt;
  logic              ovf_r, ovf_nxt;

  logic              out_valid_r, out_valid_nxt;
  letter_t           out_letter_r, out_letter_nxt;
  logic [WLEN_W-1:0] out_len_r, out_len_nxt;
  logic              out_canc_r, out_canc_nxt;
  logic              out_ovf_r, out_ovf_nxt;

  // Letter memory ports.
  logic              ram_we;
  addr_t             ram_waddr;
  letter_t           ram_wdata;
  addr_t             ram_raddr;
  logic [GEN_W-1:0]  ram_rdata;
  letter_t           rd;

  // Working values of the current step.
  logic              fin;
  logic              is_right;
  logic              match;
  logic [NG_W-1:0]   n_eff;
  rank_t             top;
  rank_t             r_cur;
  rank_t             r_inv;
  rank_t             c_cand;
  letter_t           fill_ltr;

  fge_ram #(
    .WIDTH (GEN_W),
    .DEPTH (MAX_LEN)
  ) u_letters (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd = letter_t'(ram_rdata);

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.letter      = out_letter_r;
  assign out_ch.word_length = out_len_r;
  assign out_ch.cancelled   = out_canc_r;
  assign out_ch.overflow    = out_ovf_r;

  // The generator count is clamped into 1..MAX_GENS; letters whose rank
  // reaches 2*n_eff are past the end of the alphabet and carry.
  always_comb begin
    if (ng_r == '0) begin
      n_eff = NG_W'(1);
    end else if (ng_r > NG_W'(MAX_GENS)) begin
      n_eff = NG_W'(MAX_GENS);
    end else begin
      n_eff = ng_r;
    end
    top = rank_t'({n_eff, 1'b0});
  end

  // Next-word step at one position: try the rank just above the current
  // letter, skipping the inverse of the left neighbor (which would cancel).
  always_comb begin
    r_cur  = rank_of(tmp_r, 1'b0);
    r_inv  = rank_of(rd, 1'b1);
    c_cand = r_cur + 1'b1;
    if ((pos_r != '0) && (c_cand == r_inv)) begin
      c_cand = r_cur + rank_t'(2);
    end
  end

  assign fill_ltr = (tmp_r == LTR_M_ONE) ? LTR_M_ONE : LTR_ONE;
  assign is_right = (func_r == FN_MUL_R);
  assign match    = (len_r != '0) && (rd == neg_letter(gen_r));

  always_comb begin
    state_nxt      = state_r;
    func_nxt       = func_r;
    gen_nxt        = gen_r;
    idx_nxt        = idx_r;
    len_nxt        = len_r;
    sp_nxt         = sp_r;
    ng_nxt         = ng_r;
    pos_nxt        = pos_r;
    tmp_nxt        = tmp_r;
    letter_nxt     = letter_r;
    canc_nxt       = canc_r;
    ovf_nxt        = ovf_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_letter_nxt = out_letter_r;
    out_len_nxt    = out_len_r;
    out_canc_nxt   = out_canc_r;
    out_ovf_nxt    = out_ovf_r;
    ram_we         = 1'b0;
    ram_waddr      = sp_r;
    ram_wdata      = LTR_ZERO;
    ram_raddr      = sp_r;
    fin            = 1'b0;

    if (cfg_ch.valid) begin
      ng_nxt = cfg_ch.num_gens;
    end

    unique case (state_r)
      S_IDLE: begin
        // The end letter or the indexed letter is fetched while accepting.
        case (func_t'(in_ch.func))
          FN_MUL_R: ram_raddr = slot_addr(sp_r, len_r - 1'b1);
          FN_READ:  ram_raddr = slot_addr(sp_r, LEN_W'(in_ch.index));
          default:  ram_raddr = sp_r;
        endcase
        if (in_ch.valid) begin
          func_nxt   = func_t'(in_ch.func);
          gen_nxt    = in_ch.gen;
          idx_nxt    = in_ch.index;
          letter_nxt = LTR_ZERO;
          canc_nxt   = 1'b0;
          ovf_nxt    = 1'b0;
          case (func_t'(in_ch.func))
            FN_MUL_R, FN_MUL_L: begin
              state_nxt = S_MUL_EVAL;
            end
            FN_INV: begin
              pos_nxt = '0;
              if (len_r == '0) begin
                fin = 1'b1;
              end else begin
                state_nxt = S_INV_RA;
              end
            end
            FN_NEXT: begin
              if (len_r == '0) begin
                // The empty word is followed by the single smallest letter.
                len_nxt   = len_t'(1);
                pos_nxt   = '0;
                tmp_nxt   = LTR_ZERO;
                state_nxt = S_NX_FILL;
              end else begin
                pos_nxt   = len_r - 1'b1;
                state_nxt = S_NX_RP;
              end
            end
            FN_READ: begin
              state_nxt = S_RD_DATA;
            end
            FN_SET: begin
              if (gen_ok(in_ch.gen)) begin
                sp_nxt = '0;
                if (in_ch.gen == LTR_ZERO) begin
                  len_nxt = '0;
                end else begin
                  len_nxt   = len_t'(1);
                  ram_we    = 1'b1;
                  ram_waddr = '0;
                  ram_wdata = in_ch.gen;
                end
              end
              fin = 1'b1;
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end

      S_MUL_EVAL: begin
        if ((gen_r != LTR_ZERO) && gen_ok(gen_r)) begin
          if (match) begin
            // The new letter cancels the adjacent end letter.
            len_nxt  = len_r - 1'b1;
            canc_nxt = 1'b1;
            if (!is_right) begin
              sp_nxt = (sp_r == addr_t'(MAX_LEN - 1)) ? '0 : sp_r + 1'b1;
            end
          end else if (len_r == len_t'(MAX_LEN)) begin
            ovf_nxt = 1'b1;
          end else begin
            len_nxt   = len_r + 1'b1;
            ram_we    = 1'b1;
            ram_wdata = gen_r;
            if (is_right) begin
              ram_waddr = slot_addr(sp_r, len_r);
            end else begin
              sp_nxt    = (sp_r == '0) ? addr_t'(MAX_LEN - 1) : sp_r - 1'b1;
              ram_waddr = sp_nxt;
            end
          end
        end
        fin = 1'b1;
      end

      S_RD_DATA: begin
        if (CMP_W'(idx_r) < CMP_W'(len_r)) begin
          letter_nxt = rd;
        end
        fin = 1'b1;
      end

      // Invert swaps letter pairs from both ends inward, negating each.
      S_INV_RA: begin
        ram_raddr = slot_addr(sp_r, pos_r);
        state_nxt = S_INV_RB;
      end
      S_INV_RB: begin
        ram_raddr = slot_addr(sp_r, len_r - 1'b1 - pos_r);
        tmp_nxt   = rd;
        state_nxt = S_INV_WA;
      end
      S_INV_WA: begin
        ram_we    = 1'b1;
        ram_waddr = slot_addr(sp_r, pos_r);
        ram_wdata = neg_letter(rd);
        state_nxt = S_INV_WB;
      end
      S_INV_WB: begin
        ram_we    = 1'b1;
        ram_waddr = slot_addr(sp_r, len_r - 1'b1 - pos_r);
        ram_wdata = neg_letter(tmp_r);
        pos_nxt   = pos_r + 1'b1;
        if ((pos_r + 1'b1) < len_t'((LEN_W+1)'((LEN_W+1)'(len_r) + 1'b1) >> 1)) begin
          state_nxt = S_INV_RA;
        end else begin
          fin = 1'b1;
        end
      end

      // Next word scans from the right for a letter that can be raised.
      S_NX_RP: begin
        ram_raddr = slot_addr(sp_r, pos_r);
        state_nxt = S_NX_RQ;
      end
      S_NX_RQ: begin
        ram_raddr = slot_addr(sp_r, pos_r - 1'b1);
        tmp_nxt   = rd;
        state_nxt = S_NX_EVAL;
      end
      S_NX_EVAL: begin
        if (c_cand < top) begin
          ram_we    = 1'b1;
          ram_waddr = slot_addr(sp_r, pos_r);
          ram_wdata = letter_of(c_cand);
          tmp_nxt   = letter_of(c_cand);
          pos_nxt   = pos_r + 1'b1;
          state_nxt = S_NX_FILL;
        end else if (pos_r != '0) begin
          pos_nxt   = pos_r - 1'b1;
          state_nxt = S_NX_RP;
        end else if (len_r == len_t'(MAX_LEN)) begin
          // Already the last word of the longest length.
          ovf_nxt = 1'b1;
          fin     = 1'b1;
        end else begin
          len_nxt   = len_r + 1'b1;
          pos_nxt   = '0;
          tmp_nxt   = LTR_ZERO;
          state_nxt = S_NX_FILL;
        end
      end
      S_NX_FILL: begin
        // The tail becomes the smallest reduced continuation.
        if (pos_r < len_r) begin
          ram_we    = 1'b1;
          ram_waddr = slot_addr(sp_r, pos_r);
          ram_wdata = fill_ltr;
          tmp_nxt   = fill_ltr;
          pos_nxt   = pos_r + 1'b1;
        end else begin
          fin = 1'b1;
        end
      end

      S_DONE: begin
        fin = 1'b1;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Finished work goes straight to the output register when it is free;
    // otherwise it waits in S_DONE.
    if (fin) begin
      if (!out_valid_r || out_ch.ready) begin
        out_valid_nxt  = 1'b1;
        out_letter_nxt = letter_nxt;
        out_len_nxt    = WLEN_W'(len_nxt);
        out_canc_nxt   = canc_nxt;
        out_ovf_nxt    = ovf_nxt;
        state_nxt      = S_IDLE;
      end else begin
        state_nxt = S_DONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= '0;
      sp_r        <= '0;
      ng_r        <= NG_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      sp_r        <= sp_nxt;
      ng_r        <= ng_nxt;
      out_valid_r <= out_valid_nxt;
    end
    func_r       <= func_nxt;
    gen_r        <= gen_nxt;
    idx_r        <= idx_nxt;
    pos_r        <= pos_nxt;
    tmp_r        <= tmp_nxt;
    letter_r     <= letter_nxt;
    canc_r       <= canc_nxt;
    ovf_r        <= ovf_nxt;
    out_letter_r <= out_letter_nxt;
    out_len_r    <= out_len_nxt;
    out_canc_r   <= out_canc_nxt;
    out_ovf_r    <= out_ovf_nxt;
  end

endmodule
